>>> hw/rtl/rwhp_pkg.sv
// Package of the RIFF/WAVE header parser: parse phases, status codes,
// identifier constants, sequencer states and the command, status and result structs.
// No dependencies.
package rwhp_pkg;

  // Identifiers as they are gathered, first byte in the top bits.
  localparam logic [31:0] ID_RIFF   = 32'h5249_4646;
  localparam logic [31:0] ID_RIFX   = 32'h5249_4658;
  localparam logic [31:0] ID_LIST   = 32'h4c49_5354;
  localparam logic [31:0] FORM_WAVE = 32'h5741_5645;
  localparam logic [31:0] FORM_PAL  = 32'h5041_4c20;
  localparam logic [31:0] FORM_RDIB = 32'h5244_4942;
  localparam logic [31:0] FORM_RMID = 32'h524d_4944;
  localparam logic [31:0] FORM_RMMP = 32'h524d_4d50;
  localparam logic [31:0] SUB_FMT   = 32'h666d_7420;
  localparam logic [31:0] SUB_DATA  = 32'h6461_7461;
  localparam logic [7:0]  LOWER_A   = 8'h61;
  localparam logic [7:0]  LOWER_Z   = 8'h7a;

  // Byte offsets inside the fmt body at which a field is complete.
  localparam logic [4:0] FMT_OFS_FORMAT   = 5'd1;
  localparam logic [4:0] FMT_OFS_CHANNELS = 5'd3;
  localparam logic [4:0] FMT_OFS_RATE     = 5'd7;
  localparam logic [4:0] FMT_OFS_BYTERATE = 5'd11;
  localparam logic [4:0] FMT_OFS_ALIGN    = 5'd13;
  localparam logic [4:0] FMT_OFS_BITS     = 5'd15;
  localparam logic [4:0] FMT_OFS_EXTRA    = 5'd17;

  localparam logic [32:0] BYTES_MAX = 33'h1_FFFF_FFFF;
  localparam int unsigned RES_W     = 216;

  typedef enum logic [3:0] {
    ST_DONE         = 4'd0,
    ST_BAD_SUB_ID   = 4'd1,
    ST_RIFX_LIST    = 4'd2,
    ST_BAD_OUTER    = 4'd3,
    ST_UNEXP_OUTER  = 4'd4,
    ST_FORM_UNSUP   = 4'd5,
    ST_FORM_INVALID = 4'd6,
    ST_EXTRA_PARAMS = 4'd7,
    ST_FMT_SHORT    = 4'd8,
    ST_TRUNCATED    = 4'd9
  } status_e;

  typedef enum logic [9:0] {
    PH_OUTER_ID   = 10'b00_0000_0001,
    PH_OUTER_SIZE = 10'b00_0000_0010,
    PH_FORM       = 10'b00_0000_0100,
    PH_SUB_ID     = 10'b00_0000_1000,
    PH_SIZE_FMT   = 10'b00_0001_0000,
    PH_SIZE_DATA  = 10'b00_0010_0000,
    PH_SIZE_OTHER = 10'b00_0100_0000,
    PH_FMT_BODY   = 10'b00_1000_0000,
    PH_SKIP       = 10'b01_0000_0000,
    PH_STOP       = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [3:0] {
    SQ_RUN  = 4'b0001,
    SQ_MUL  = 4'b0010,
    SQ_PROD = 4'b0100,
    SQ_OUT  = 4'b1000
  } seq_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    gather_be;
    logic    gather_le;
    logic    bif_inc;
    logic    bif_clr;
    logic    count_byte;
    logic    load_riff;
    logic    load_cur;
    logic    load_data;
    logic    count_chunk;
    logic    load_fmt;
    logic    skip_load_size;
    logic    skip_load_rest;
    logic    skip_dec;
    logic    mul_cb;
    logic    mul_prod;
    logic    load_out;
    logic    clear_all;
    status_e status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic field_end;
    logic is_riff;
    logic is_rifx_list;
    logic id_bad;
    logic is_wave;
    logic is_form_unsup;
    logic is_fmt;
    logic is_data;
    logic size_short;
    logic size_zero;
    logic bif_is15;
    logic bif_is17;
    logic cur_is16;
    logic cur_is18;
    logic extra_nz;
    logic skip_one;
  } dp_stat_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  checks;
    logic [15:0] chunk_count;
    logic [31:0] riff_size;
    logic [31:0] data_size;
    logic [15:0] bits_per_sample;
    logic [15:0] block_align;
    logic [31:0] byte_rate;
    logic [31:0] sample_rate;
    logic [15:0] num_channels;
    logic [15:0] audio_format;
    status_e     status;
  } result_t;

  // A letter, a digit or a space.
  function automatic logic id_char(input logic [7:0] b);
    id_char = (b == 8'h20) || (b >= LOWER_A && b <= LOWER_Z) ||
              (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h30 && b <= 8'h39);
  endfunction

  function automatic logic id_bad(input logic [31:0] w);
    id_bad = !(id_char(w[7:0]) && id_char(w[15:8]) &&
               id_char(w[23:16]) && id_char(w[31:24]));
  endfunction

endpackage

>>> hw/rtl/riff_wave_header_parser.sv
// Top level of the RIFF/WAVE header parser: controller, datapath and the
// stream ports. Depends on rwhp_pkg, rwhp_ctrl, rwhp_dp.
//
//   Channel  Direction  Payload                          Beats
//   s_axis   in         tdata: in_byte, tlast: end_of_file  one per file byte
//   m_axis   out        tdata: result fields             one per file
//
// Byte beats are taken only in the run state of the sequencer. After the beat
// marked tlast no byte is taken while the sequencer steps through the two
// multiply stages of the check unit and the load of the result register. The
// load waits while an earlier result beat is still held. Asynchronous reset
// clears all parse state and drops m_axis_tvalid; there is no clearing pass.
module riff_wave_header_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] in_byte
  input  logic         s_axis_tlast,   // end_of_file
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [215:0] m_axis_tdata    // [3:0] status, [19:4] audio_format,
                                       // [35:20] num_channels,
                                       // [67:36] sample_rate,
                                       // [99:68] byte_rate,
                                       // [115:100] block_align,
                                       // [131:116] bits_per_sample,
                                       // [163:132] data_size,
                                       // [195:164] riff_size,
                                       // [211:196] chunk_count,
                                       // [214:212] checks, [215] zero
);
  import rwhp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  res;
  logic     last_beat;

  rwhp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rwhp_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (s_axis_tdata),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res)
  );

  // Result fields packed from the lowest bit up.
  assign m_axis_tdata = {1'b0, res.checks, res.chunk_count, res.riff_size,
                         res.data_size, res.bits_per_sample, res.block_align,
                         res.byte_rate, res.sample_rate, res.num_channels,
                         res.audio_format, res.status};

  assign last_beat = s_axis_tvalid && s_axis_tready && s_axis_tlast;

  // No byte is taken in the cycle after the final beat.
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_beat |=> !s_axis_tready)
    else $error("byte accepted while checks are running");

  // A fresh result beat is raised only after a final byte, once the multiply
  // stages have run and the result register is loaded.
  a_result_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(last_beat, 4))
    else $error("result beat without a matching final byte");

  // Only defined status codes leave the block.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3:0] <= ST_TRUNCATED))
    else $error("undefined status code on result beat");

endmodule

>>> hw/rtl/rwhp_chk.sv
// Consistency check unit: two registered multiply stages and the final
// compares of byte rate, block align and outer size. Depends on rwhp_pkg.
module rwhp_chk (
  input  logic        clk_i,
  input  logic        mul_cb_i,
  input  logic        mul_prod_i,
  input  logic [15:0] channels_i,
  input  logic [15:0] bits_i,
  input  logic [31:0] rate_i,
  input  logic [31:0] byte_rate_i,
  input  logic [15:0] align_i,
  input  logic [31:0] riff_size_i,
  input  logic [32:0] bytes_seen_i,
  output logic [2:0]  checks_o
);
  import rwhp_pkg::*;

  logic [31:0] cb_q;
  logic [63:0] prod_q;

  // Channels times bits first, then times the sample rate.
  always_ff @(posedge clk_i) begin
    if (mul_cb_i) begin
      cb_q <= channels_i * bits_i;
    end
    if (mul_prod_i) begin
      prod_q <= rate_i * cb_q;
    end
  end

  // Division by eight is a drop of the three low bits.
  assign checks_o[0] = (prod_q[63:3] == {29'd0, byte_rate_i});
  assign checks_o[1] = (cb_q[31:3] == {13'd0, align_i});
  assign checks_o[2] = (({1'b0, riff_size_i} + 33'd8) == bytes_seen_i);

endmodule

>>> hw/rtl/rwhp_dp.sv
// Datapath of the parser: byte gathering, sizes, skip counter, held fmt
// fields, counters and the result register. Depends on rwhp_pkg, rwhp_chk.
module rwhp_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         byte_i,
  input  rwhp_pkg::dp_cmd_t  cmd_i,
  output rwhp_pkg::dp_stat_t stat_o,
  output rwhp_pkg::result_t  res_o
);
  import rwhp_pkg::*;

  logic [31:0] gw_q, gw_d;
  logic [4:0]  bif_q, bif_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] cur_q, cur_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] brate_q, brate_d;
  logic [15:0] align_q, align_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] dsize_q, dsize_d;
  logic [31:0] rsize_q, rsize_d;
  logic [32:0] bytes_q, bytes_d;
  logic [15:0] chunks_q, chunks_d;
  logic [31:0] gw_be;
  logic [31:0] gw_le;
  logic [2:0]  checks;
  result_t     res_q;

  // Next gathered word in either byte order.
  assign gw_be = {gw_q[23:0], byte_i};
  assign gw_le = {byte_i, gw_q[31:8]};

  // Classification of the word that this beat completes.
  always_comb begin
    stat_o.field_end     = (bif_q == 5'd3);
    stat_o.is_riff       = (gw_be == ID_RIFF);
    stat_o.is_rifx_list  = (gw_be == ID_RIFX) || (gw_be == ID_LIST);
    stat_o.id_bad        = id_bad(gw_be);
    stat_o.is_wave       = (gw_be == FORM_WAVE);
    stat_o.is_form_unsup = (gw_be == FORM_PAL) || (gw_be == FORM_RDIB) ||
                           (gw_be == FORM_RMID) || (gw_be == FORM_RMMP);
    stat_o.is_fmt        = (gw_be == SUB_FMT);
    stat_o.is_data       = (gw_be == SUB_DATA);
    stat_o.size_short    = (gw_le < 32'd16) || (gw_le == 32'd17);
    stat_o.size_zero     = (gw_le == 32'd0);
    stat_o.bif_is15      = (bif_q == FMT_OFS_BITS);
    stat_o.bif_is17      = (bif_q == FMT_OFS_EXTRA);
    stat_o.cur_is16      = (cur_q == 32'd16);
    stat_o.cur_is18      = (cur_q == 32'd18);
    stat_o.extra_nz      = (gw_le[31:16] != 16'd0);
    stat_o.skip_one      = (skip_q == 32'd1);
  end

  // Next values of the parse state.
  always_comb begin
    gw_d     = gw_q;
    bif_d    = bif_q;
    skip_d   = skip_q;
    cur_d    = cur_q;
    fmt_d    = fmt_q;
    chan_d   = chan_q;
    rate_d   = rate_q;
    brate_d  = brate_q;
    align_d  = align_q;
    bits_d   = bits_q;
    dsize_d  = dsize_q;
    rsize_d  = rsize_q;
    bytes_d  = bytes_q;
    chunks_d = chunks_q;

    if (cmd_i.gather_be) begin
      gw_d = gw_be;
    end else if (cmd_i.gather_le) begin
      gw_d = gw_le;
    end
    if (cmd_i.bif_clr) begin
      bif_d = 5'd0;
    end else if (cmd_i.bif_inc) begin
      bif_d = bif_q + 5'd1;
    end
    if (cmd_i.count_byte && bytes_q != BYTES_MAX) begin
      bytes_d = bytes_q + 33'd1;
    end
    if (cmd_i.load_riff) begin
      rsize_d = gw_le;
    end
    if (cmd_i.load_cur) begin
      cur_d = gw_le;
    end
    if (cmd_i.load_data) begin
      dsize_d = gw_le;
    end
    if (cmd_i.count_chunk && chunks_q != 16'hFFFF) begin
      chunks_d = chunks_q + 16'd1;
    end

    // Skip counter: loaded from a header size or the rest of a fmt body.
    if (cmd_i.skip_load_size) begin
      skip_d = gw_le;
    end else if (cmd_i.skip_load_rest) begin
      skip_d = cur_q - 32'd18;
    end else if (cmd_i.skip_dec && skip_q != 32'd0) begin
      skip_d = skip_q - 32'd1;
    end

    // Fmt fields, taken as each one completes.
    if (cmd_i.load_fmt) begin
      case (bif_q)
        FMT_OFS_FORMAT:   fmt_d   = gw_le[31:16];
        FMT_OFS_CHANNELS: chan_d  = gw_le[31:16];
        FMT_OFS_RATE:     rate_d  = gw_le;
        FMT_OFS_BYTERATE: brate_d = gw_le;
        FMT_OFS_ALIGN:    align_d = gw_le[31:16];
        FMT_OFS_BITS:     bits_d  = gw_le[31:16];
        default: ;
      endcase
    end

    // A new file starts from the reset state.
    if (cmd_i.clear_all) begin
      gw_d     = '0;
      bif_d    = '0;
      skip_d   = '0;
      cur_d    = '0;
      fmt_d    = '0;
      chan_d   = '0;
      rate_d   = '0;
      brate_d  = '0;
      align_d  = '0;
      bits_d   = '0;
      dsize_d  = '0;
      rsize_d  = '0;
      bytes_d  = '0;
      chunks_d = '0;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q     <= '0;
      bif_q    <= '0;
      skip_q   <= '0;
      cur_q    <= '0;
      fmt_q    <= '0;
      chan_q   <= '0;
      rate_q   <= '0;
      brate_q  <= '0;
      align_q  <= '0;
      bits_q   <= '0;
      dsize_q  <= '0;
      rsize_q  <= '0;
      bytes_q  <= '0;
      chunks_q <= '0;
    end else begin
      gw_q     <= gw_d;
      bif_q    <= bif_d;
      skip_q   <= skip_d;
      cur_q    <= cur_d;
      fmt_q    <= fmt_d;
      chan_q   <= chan_d;
      rate_q   <= rate_d;
      brate_q  <= brate_d;
      align_q  <= align_d;
      bits_q   <= bits_d;
      dsize_q  <= dsize_d;
      rsize_q  <= rsize_d;
      bytes_q  <= bytes_d;
      chunks_q <= chunks_d;
    end
  end

  rwhp_chk u_chk (
    .clk_i        (clk_i),
    .mul_cb_i     (cmd_i.mul_cb),
    .mul_prod_i   (cmd_i.mul_prod),
    .channels_i   (chan_q),
    .bits_i       (bits_q),
    .rate_i       (rate_q),
    .byte_rate_i  (brate_q),
    .align_i      (align_q),
    .riff_size_i  (rsize_q),
    .bytes_seen_i (bytes_q),
    .checks_o     (checks)
  );

  // Result register, loaded once the checks are ready.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_q.status          <= cmd_i.status;
      res_q.audio_format    <= fmt_q;
      res_q.num_channels    <= chan_q;
      res_q.sample_rate     <= rate_q;
      res_q.byte_rate       <= brate_q;
      res_q.block_align     <= align_q;
      res_q.bits_per_sample <= bits_q;
      res_q.data_size       <= dsize_q;
      res_q.riff_size       <= rsize_q;
      res_q.chunk_count     <= chunks_q;
      res_q.checks          <= checks;
    end
  end

  assign res_o = res_q;

endmodule

>>> hw/rtl/rwhp_ctrl.sv
// Controller of the parser: the parse phase machine, the held status and
// the sequencer for the final checks and the result beat. Depends on rwhp_pkg.
module rwhp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  rwhp_pkg::dp_stat_t stat_i,
  output rwhp_pkg::dp_cmd_t  cmd_o
);
  import rwhp_pkg::*;

  phase_e  phase_q, phase_d;
  seq_e    seq_q, seq_d;
  status_e status_q, status_d;
  status_e res_status_q, res_status_d;
  logic    out_valid_q, out_valid_d;
  logic    beat;
  logic    sub_done;

  assign in_ready_o  = (seq_q == SQ_RUN);
  assign beat        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    phase_d      = phase_q;
    seq_d        = seq_q;
    status_d     = status_q;
    res_status_d = res_status_q;

    // Parse step for one accepted beat.
    if (beat) begin
      cmd_o.count_byte = 1'b1;
      case (phase_q)
        PH_OUTER_ID: begin
          cmd_o.gather_be = 1'b1;
          if (stat_i.field_end) begin
            cmd_o.bif_clr = 1'b1;
            if (stat_i.is_riff) begin
              phase_d = PH_OUTER_SIZE;
            end else if (stat_i.is_rifx_list) begin
              phase_d  = PH_STOP;
              status_d = ST_RIFX_LIST;
            end else begin
              phase_d  = PH_STOP;
              status_d = stat_i.id_bad ? ST_BAD_OUTER : ST_UNEXP_OUTER;
            end
          end else begin
            cmd_o.bif_inc = 1'b1;
          end
        end
        PH_OUTER_SIZE: begin
          cmd_o.gather_le = 1'b1;
          if (stat_i.field_end) begin
            cmd_o.bif_clr   = 1'b1;
            cmd_o.load_riff = 1'b1;
            phase_d         = PH_FORM;
          end else begin
            cmd_o.bif_inc = 1'b1;
          end
        end
        PH_FORM: begin
          cmd_o.gather_be = 1'b1;
          if (stat_i.field_end) begin
            cmd_o.bif_clr = 1'b1;
            if (stat_i.is_wave) begin
              phase_d = PH_SUB_ID;
            end else begin
              phase_d  = PH_STOP;
              status_d = stat_i.is_form_unsup ? ST_FORM_UNSUP : ST_FORM_INVALID;
            end
          end else begin
            cmd_o.bif_inc = 1'b1;
          end
        end
        PH_SUB_ID: begin
          cmd_o.gather_be = 1'b1;
          if (stat_i.field_end) begin
            cmd_o.bif_clr = 1'b1;
            if (stat_i.is_fmt) begin
              phase_d = PH_SIZE_FMT;
            end else if (stat_i.is_data) begin
              phase_d = PH_SIZE_DATA;
            end else if (stat_i.id_bad) begin
              phase_d  = PH_STOP;
              status_d = ST_BAD_SUB_ID;
            end else begin
              phase_d = PH_SIZE_OTHER;
            end
          end else begin
            cmd_o.bif_inc = 1'b1;
          end
        end
        PH_SIZE_FMT: begin
          cmd_o.gather_le = 1'b1;
          if (stat_i.field_end) begin
            cmd_o.bif_clr  = 1'b1;
            cmd_o.load_cur = 1'b1;
            if (stat_i.size_short) begin
              phase_d  = PH_STOP;
              status_d = ST_FMT_SHORT;
            end else begin
              cmd_o.count_chunk = 1'b1;
              phase_d           = PH_FMT_BODY;
            end
          end else begin
            cmd_o.bif_inc = 1'b1;
          end
        end
        PH_SIZE_DATA, PH_SIZE_OTHER: begin
          cmd_o.gather_le = 1'b1;
          if (stat_i.field_end) begin
            cmd_o.bif_clr        = 1'b1;
            cmd_o.load_cur       = 1'b1;
            cmd_o.load_data      = (phase_q == PH_SIZE_DATA);
            cmd_o.count_chunk    = 1'b1;
            cmd_o.skip_load_size = 1'b1;
            phase_d              = stat_i.size_zero ? PH_SUB_ID : PH_SKIP;
          end else begin
            cmd_o.bif_inc = 1'b1;
          end
        end
        PH_FMT_BODY: begin
          cmd_o.gather_le = 1'b1;
          cmd_o.load_fmt  = 1'b1;
          if (stat_i.bif_is15 && stat_i.cur_is16) begin
            cmd_o.bif_clr = 1'b1;
            phase_d       = PH_SUB_ID;
          end else if (stat_i.bif_is17) begin
            cmd_o.bif_clr = 1'b1;
            if (stat_i.extra_nz) begin
              phase_d  = PH_STOP;
              status_d = ST_EXTRA_PARAMS;
            end else begin
              cmd_o.skip_load_rest = 1'b1;
              phase_d              = stat_i.cur_is18 ? PH_SUB_ID : PH_SKIP;
            end
          end else begin
            cmd_o.bif_inc = 1'b1;
          end
        end
        PH_SKIP: begin
          cmd_o.skip_dec = 1'b1;
          if (stat_i.skip_one) begin
            phase_d = PH_SUB_ID;
          end
        end
        PH_STOP: ;
        default: phase_d = PH_STOP;
      endcase
    end

    // A clean end lands on a subchunk boundary with no id byte gathered.
    sub_done = (phase_d == PH_SUB_ID) &&
               !((phase_q == PH_SUB_ID) && !stat_i.field_end);

    // The final beat fixes the status and starts the check sequence.
    if (beat && in_last_i) begin
      seq_d = SQ_MUL;
      if (phase_d == PH_STOP) begin
        res_status_d = status_d;
      end else if (sub_done) begin
        res_status_d = ST_DONE;
      end else begin
        res_status_d = ST_TRUNCATED;
      end
    end

    // Check sequence and hand-off to the result register.
    case (seq_q)
      SQ_RUN: ;
      SQ_MUL: begin
        cmd_o.mul_cb = 1'b1;
        seq_d        = SQ_PROD;
      end
      SQ_PROD: begin
        cmd_o.mul_prod = 1'b1;
        seq_d          = SQ_OUT;
      end
      SQ_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.clear_all = 1'b1;
          phase_d         = PH_OUTER_ID;
          status_d        = ST_DONE;
          seq_d           = SQ_RUN;
        end
      end
      default: seq_d = SQ_RUN;
    endcase

    cmd_o.status = res_status_q;
  end

  // Result beat valid flag.
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_OUTER_ID;
      seq_q        <= SQ_RUN;
      status_q     <= ST_DONE;
      res_status_q <= ST_DONE;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      seq_q        <= seq_d;
      status_q     <= status_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
    end
  end

endmodule
